FILE: sv/rsmc_pkg.sv
// Shared constants for the range second-max count tree.
package rsmc_pkg;

  localparam int MAX_POSITIONS_DEF = 1024;
  localparam int VALUE_BITS_DEF    = 30;

  // Command codes carried in the input word
  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

FILE: sv/rsmc_in_if.sv
// Command channel: valid/ready handshake carrying one set or query word.
interface rsmc_in_if #(
  parameter int PW = $clog2(rsmc_pkg::MAX_POSITIONS_DEF + 1),
  parameter int VB = rsmc_pkg::VALUE_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic          command;
  logic [PW-1:0] position;
  logic [PW-1:0] range_end;
  logic [VB-1:0] new_value;

  modport source (output valid, command, position, range_end, new_value, input ready);
  modport sink   (input valid, command, position, range_end, new_value, output ready);
endinterface

FILE: sv/rsmc_out_if.sv
// Result channel: valid/ready handshake carrying one query result word.
interface rsmc_out_if #(
  parameter int CW = $clog2(rsmc_pkg::MAX_POSITIONS_DEF + 1)
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] second_count;

  modport source (output valid, second_count, input ready);
  modport sink   (input valid, second_count, output ready);
endinterface

FILE: sv/rsmc_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
module rsmc_ram #(
  parameter int WIDTH = 84,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/range_second_max_count_tree.sv
// Segment tree tracking top two distinct values and their counts, with set and query.
//
// Usage:
//  - in_ch takes one word per command. command = set writes new_value at position
//    (ignored when position is 0 or above active_count) and gives no result.
//    command = query returns, on out_ch, how often the second-largest distinct
//    value occurs in position..range_end (0 if none or the range is empty).
//  - cfg_we/cfg_data write active_count, clamped to 1..MAX_POSITIONS; write it
//    only while the block is idle. Stored nodes are kept across resizes.
//  - One command at a time: in_ch.ready is high only while the sequencer idles.
//    A set walks down the tree one level per cycle, then back up one level per
//    cycle (sibling read and parent write overlap in the node RAM).
//  - A query walks the tree depth first with a small stack, one node per cycle,
//    then takes a finishing step. The node RAM read port and the single merge
//    unit set this pace.
//  - Result goes to an output register; a stalled receiver does not block new
//    commands, only the finishing step of the next query.
//  - After reset all 4*MAX_POSITIONS node RAM entries (4096 at default) are
//    cleared one entry per cycle, with in_ch.ready low; cfg writes are taken.
module range_second_max_count_tree #(
  parameter int MAX_POSITIONS = rsmc_pkg::MAX_POSITIONS_DEF,
  parameter int VALUE_BITS    = rsmc_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rsmc_in_if.sink                            in_ch,
  rsmc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [$clog2(MAX_POSITIONS+1)-1:0] cfg_data
);

  localparam int PW    = $clog2(MAX_POSITIONS + 1);  // position width
  localparam int CW    = PW;                         // count width
  localparam int KW    = VALUE_BITS + 1;             // key: 0 = absent, else value+1
  localparam int NODES = 4 * MAX_POSITIONS;
  localparam int IW    = $clog2(NODES);
  localparam int NW    = 2 * (KW + CW);
  localparam int SD    = $clog2(MAX_POSITIONS) + 1;  // DFS stack depth
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  // Sequencer states
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SDOWN  = 3'd2;
  localparam logic [2:0] ST_SUP    = 3'd3;
  localparam logic [2:0] ST_QWALK  = 3'd4;
  localparam logic [2:0] ST_QDRAIN = 3'd5;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [CW-1:0] cnt;
  } slot_t;

  typedef struct packed {
    slot_t top;
    slot_t sec;
  } node_t;

  // Merge two node summaries. Counts only ever add, so wrapping is harmless.
  function automatic node_t merge_nodes(node_t a, node_t b);
    node_t x;
    node_t y;
    node_t r;
    if (a.top.key == b.top.key) begin
      if (a.sec.key < b.sec.key) begin
        x = b;
        y = a;
      end else begin
        x = a;
        y = b;
      end
      r = x;
      r.top.cnt = x.top.cnt + y.top.cnt;
      if (x.sec.key == y.sec.key) begin
        r.sec.cnt = x.sec.cnt + y.sec.cnt;
      end
    end else begin
      if (a.top.key < b.top.key) begin
        x = b;
        y = a;
      end else begin
        x = a;
        y = b;
      end
      r = x;
      if (y.top.key > x.sec.key) begin
        r.sec = y.top;
      end else if (y.top.key == x.sec.key) begin
        r.sec.cnt = x.sec.cnt + y.top.cnt;
      end
    end
    return r;
  endfunction

  logic [2:0]    state_r;
  logic [IW-1:0] clr_r;
  logic [PW-1:0] active_r;
  logic [PW-1:0] qs_r;      // set position or query left bound
  logic [PW-1:0] qe_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [IW-1:0] id_r;
  logic [PW-1:0] lo_r;
  logic [PW-1:0] hi_r;
  node_t         cur_r;     // node just written on the way up
  node_t         acc_r;     // query accumulator
  logic          pend_r;    // a covering node read is in flight
  logic [SPW-1:0] sp_r;
  logic [IW-1:0] stk_id_r [SD];
  logic [PW-1:0] stk_lo_r [SD];
  logic [PW-1:0] stk_hi_r [SD];
  logic          out_valid_r;
  logic [CW-1:0] out_cnt_r;

  logic [PW-1:0] mid;
  logic          is_leaf;
  logic          disjoint;
  logic          covered;
  logic [IW-1:0] par_id;
  logic [IW-1:0] left_id;
  logic [SIW-1:0] push_idx;
  logic [SIW-1:0] pop_idx;
  node_t         leaf_node;
  node_t         rd_node;
  node_t         mrg_a;
  node_t         mrg_out;
  node_t         acc_fin;
  logic [PW-1:0] cfg_clamped;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [NW-1:0] ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [NW-1:0] ram_rdata;

  rsmc_ram #(
    .WIDTH (NW),
    .DEPTH (NODES)
  ) u_nodes (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_node  = node_t'(ram_rdata);
  assign mid      = lo_r + PW'((hi_r - lo_r) >> 1);
  assign is_leaf  = (lo_r == hi_r);
  assign disjoint = (lo_r > qe_r) || (hi_r < qs_r);
  assign covered  = (qs_r <= lo_r) && (hi_r <= qe_r);
  assign par_id   = {1'b0, id_r[IW-1:1]};
  assign left_id  = {id_r[IW-2:0], 1'b0};
  assign push_idx = sp_r[SIW-1:0];
  assign pop_idx  = SIW'(sp_r - SPW'(1));

  always_comb begin
    leaf_node         = '0;
    leaf_node.top.key = KW'(val_r) + KW'(1);
    leaf_node.top.cnt = CW'(1);
  end

  // The one merge unit: sibling merge on the way up, accumulation in a query
  assign mrg_a   = (state_r == ST_SUP) ? cur_r : acc_r;
  assign mrg_out = merge_nodes(mrg_a, rd_node);
  assign acc_fin = pend_r ? mrg_out : acc_r;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = PW'(1);
    end else if (cfg_data > PW'(MAX_POSITIONS)) begin
      cfg_clamped = PW'(MAX_POSITIONS);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  // Node RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = id_r;
    ram_wdata = NW'(leaf_node);
    ram_raddr = id_r;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      ST_SDOWN: begin
        ram_we    = is_leaf;
        ram_raddr = id_r ^ IW'(1);
      end
      ST_SUP: begin
        ram_we    = 1'b1;
        ram_waddr = par_id;
        ram_wdata = NW'(mrg_out);
        ram_raddr = par_id ^ IW'(1);
      end
      default: begin
        ram_raddr = id_r;
      end
    endcase
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.second_count = out_cnt_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      active_r    <= PW'(MAX_POSITIONS);
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      sp_r        <= '0;
    end else begin
      if (cfg_we) begin
        active_r <= cfg_clamped;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      pend_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + IW'(1);
          if (clr_r == IW'(NODES - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          sp_r <= '0;
          if (in_ch.valid) begin
            if (in_ch.command == rsmc_pkg::CMD_QUERY) begin
              state_r <= ST_QWALK;
            end else if (in_ch.position != '0 && in_ch.position <= active_r) begin
              state_r <= ST_SDOWN;
            end
          end
        end
        ST_SDOWN: begin
          if (is_leaf) begin
            state_r <= (id_r == IW'(1)) ? ST_IDLE : ST_SUP;
          end
        end
        ST_SUP: begin
          if (par_id == IW'(1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_QWALK: begin
          if (disjoint || covered) begin
            pend_r <= covered;
            if (sp_r == '0) begin
              state_r <= ST_QDRAIN;
            end else begin
              sp_r <= sp_r - SPW'(1);
            end
          end else begin
            sp_r <= sp_r + SPW'(1);
          end
        end
        ST_QDRAIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pend_r) begin
      acc_r <= mrg_out;
    end
    case (state_r)
      ST_IDLE: begin
        qs_r  <= in_ch.position;
        qe_r  <= in_ch.range_end;
        val_r <= in_ch.new_value;
        id_r  <= IW'(1);
        lo_r  <= PW'(1);
        hi_r  <= active_r;
        acc_r <= '0;
      end
      ST_SDOWN: begin
        if (is_leaf) begin
          cur_r <= leaf_node;
        end else if (qs_r <= mid) begin
          id_r <= left_id;
          hi_r <= mid;
        end else begin
          id_r <= left_id | IW'(1);
          lo_r <= mid + PW'(1);
        end
      end
      ST_SUP: begin
        cur_r <= mrg_out;
        id_r  <= par_id;
      end
      ST_QWALK: begin
        if (disjoint || covered) begin
          if (sp_r != '0) begin
            id_r <= stk_id_r[pop_idx];
            lo_r <= stk_lo_r[pop_idx];
            hi_r <= stk_hi_r[pop_idx];
          end
        end else begin
          // descend left, keep the right half for later
          stk_id_r[push_idx] <= left_id | IW'(1);
          stk_lo_r[push_idx] <= mid + PW'(1);
          stk_hi_r[push_idx] <= hi_r;
          id_r <= left_id;
          hi_r <= mid;
        end
      end
      ST_QDRAIN: begin
        // a result still waiting in the output register stays put
        if (!out_valid_r || out_ch.ready) begin
          out_cnt_r <= (acc_fin.sec.key != '0) ? acc_fin.sec.cnt : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Stack never grows past the tree height
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QWALK && !disjoint && !covered) |-> (sp_r < SPW'(SD)))
    else $error("query stack overflow");

  // Walking up, the sibling read never hits the parent being written
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUP) |-> (ram_waddr != ram_raddr))
    else $error("node read collides with node write");

  // A result only appears at the end of a query
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_QDRAIN))
    else $error("result without a finished query");

  // Covering node reads are only issued by the query walk
  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ($past(state_r) == ST_QWALK))
    else $error("stray pending node read");

  // The leaf write ends the descent within the node range
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SDOWN && is_leaf) |=> (state_r == ST_SUP || state_r == ST_IDLE))
    else $error("set descent did not turn at the leaf");

endmodule

FILE: tb/rsmc_second_count_check.sv
// Watches the command, result and register ports, predicts each query result and compares it.
module rsmc_second_count_check #(
  parameter int MAXP = rsmc_pkg::MAX_POSITIONS_DEF,
  parameter int VB   = rsmc_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rsmc_in_if                        in_ch,
  rsmc_out_if                       out_ch,
  input  logic                      cfg_we,
  input  logic [$clog2(MAXP+1)-1:0] cfg_data,
  input  logic                      run_done,
  output int                        mismatches,
  output int                        results_due,
  output int                        results_seen,
  output int                        nonzero_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES = 4 * MAXP;

  typedef struct packed {
    logic          present;
    logic [VB-1:0] value;
    logic [31:0]   count;
  } slot_t;

  typedef struct packed {
    slot_t top;
    slot_t sec;
  } node_t;

  node_t       tree_mem [0:NODES-1];
  int unsigned tree_span;
  logic [10:0] counts_due [$];

  // absent sorts below every present value
  function automatic logic [VB:0] key_of(slot_t s);
    return s.present ? ({1'b0, s.value} + 1'b1) : '0;
  endfunction

  function automatic node_t merge_nodes(node_t a, node_t b);
    node_t t;
    if (key_of(a.top) == key_of(b.top)) begin
      if (key_of(a.sec) < key_of(b.sec)) begin
        t = a; a = b; b = t;
      end
      a.top.count += b.top.count;
      if (key_of(a.sec) == key_of(b.sec)) a.sec.count += b.sec.count;
    end else begin
      if (key_of(a.top) < key_of(b.top)) begin
        t = a; a = b; b = t;
      end
      if (key_of(b.top) > key_of(a.sec)) a.sec = b.top;
      else if (key_of(b.top) == key_of(a.sec)) a.sec.count += b.top.count;
    end
    return a;
  endfunction

  function automatic node_t node_at(int unsigned id);
    return (id < NODES) ? tree_mem[id] : '0;
  endfunction

  // Point write: walk down to the leaf, then re-merge the path bottom up.
  function automatic void apply_set(int unsigned pos, logic [VB-1:0] val);
    int unsigned lo, hi, id, mid, depth;
    int unsigned path [0:63];
    node_t       leaf;
    int          k;
    if (pos < 1 || pos > tree_span) return;
    leaf = '0;
    leaf.top.present = 1'b1;
    leaf.top.value   = val;
    leaf.top.count   = 1;
    lo = 1; hi = tree_span; id = 1; depth = 0;
    while (id < NODES && lo != hi) begin
      path[depth] = id;
      depth++;
      mid = lo + (hi - lo) / 2;
      if (pos <= mid) begin
        hi = mid; id = 2 * id;
      end else begin
        lo = mid + 1; id = 2 * id + 1;
      end
    end
    if (id < NODES) tree_mem[id] = leaf;
    for (k = int'(depth) - 1; k >= 0; k--)
      tree_mem[path[k]] = merge_nodes(node_at(2 * path[k]), node_at(2 * path[k] + 1));
  endfunction

  // Range merge, depth first, left span before right span.
  function automatic logic [10:0] second_count_of(int unsigned first, int unsigned last);
    int unsigned stk_lo [0:63];
    int unsigned stk_hi [0:63];
    int unsigned stk_id [0:63];
    int unsigned lo, hi, id, mid;
    int          sp;
    node_t       acc;
    acc = '0;
    sp = 1;
    stk_lo[0] = 1; stk_hi[0] = tree_span; stk_id[0] = 1;
    while (sp > 0) begin
      sp--;
      lo = stk_lo[sp]; hi = stk_hi[sp]; id = stk_id[sp];
      if (lo > last || hi < first || id >= NODES) continue;
      if (first <= lo && hi <= last) begin
        acc = merge_nodes(acc, tree_mem[id]);
      end else begin
        mid = lo + (hi - lo) / 2;
        stk_lo[sp] = mid + 1; stk_hi[sp] = hi;  stk_id[sp] = 2 * id + 1;
        stk_lo[sp + 1] = lo;  stk_hi[sp + 1] = mid; stk_id[sp + 1] = 2 * id;
        sp += 2;
      end
    end
    return acc.sec.present ? acc.sec.count[10:0] : 11'd0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns check: %s", $time, what);
    mismatches++;
  endtask

  initial begin
    mismatches   = 0;
    results_due  = 0;
    results_seen = 0;
    nonzero_seen = 0;
  end

  // Result side is handled before the command side: a word taken on this
  // edge cannot have produced the result leaving on the same edge.
  always @(posedge clk) begin
    logic [10:0] want;
    if (!rst_n) begin
      for (int i = 0; i < NODES; i++) tree_mem[i] = '0;
      tree_span = MAXP;
      counts_due.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (counts_due.size() == 0) begin
          report_mismatch($sformatf("result %0d with no query waiting", out_ch.second_count));
        end else begin
          want = counts_due.pop_front();
          if (want != 0) nonzero_seen++;
          if (out_ch.second_count !== want)
            report_mismatch($sformatf("second_count %0d, expected %0d",
                                      out_ch.second_count, want));
        end
      end
      if (cfg_we)
        tree_span = (cfg_data < 1) ? 1 : (cfg_data > MAXP) ? MAXP : int'(cfg_data);
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.command == rsmc_pkg::CMD_QUERY)
          counts_due.push_back(second_count_of(32'(in_ch.position), 32'(in_ch.range_end)));
        else
          apply_set(32'(in_ch.position), in_ch.new_value);
      end
    end
    results_due = counts_due.size();
  end

  always @(posedge run_done) begin
    if (counts_due.size() != 0)
      report_mismatch($sformatf("%0d query results never arrived", counts_due.size()));
  end

endmodule

FILE: tb/range_second_max_count_tree_tb.sv
// Stimulus, clock, reset and verdict for the range second-max count tree.
module range_second_max_count_tree_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW            = $clog2(rsmc_pkg::MAX_POSITIONS_DEF + 1);
  localparam int VB            = rsmc_pkg::VALUE_BITS_DEF;
  localparam int POS_TOP       = (1 << PW) - 1;   // largest value the position field holds
  localparam int CYCLE_LIMIT   = 2_000_000;
  // A set gives no result to wait for, so this many quiet cycles cover any
  // write still walking the tree.
  localparam int SETTLE_CYCLES = 64;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_WORDS   = 170;
  localparam logic [VB-1:0] VALUE_TOP = '1;

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_we;
  logic [PW-1:0] cfg_data;
  logic          run_done;

  int mismatches, results_due, results_seen, nonzero_seen;
  int cycle_count = 0;
  int sets_sent = 0;
  int queries_sent = 0;
  int sizes_used = 0;

  // steady: a phase where neither side idles
  bit            steady = 1'b0;
  int            ready_hold = 0;
  int            win_lo, win_len;
  int            pool_n;
  logic [VB-1:0] value_pool [0:7];

  rsmc_in_if  in_ch ();
  rsmc_out_if out_ch ();

  range_second_max_count_tree DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  rsmc_second_count_check second_count_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .run_done     (run_done),
    .mismatches   (mismatches),
    .results_due  (results_due),
    .results_seen (results_seen),
    .nonzero_seen (nonzero_seen)
  );

  always #2 clk = ~clk;

  // Hard stop if the block hangs somewhere.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls on the result channel, none in steady phases.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold > 0) begin
        out_ch.ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady && $urandom_range(0, 4) == 0) ready_hold = gap_len();
      end
    end
  end

  // Drop valid for a gap of length n; no-op for n = 0.
  task automatic pause(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Present one word and hold it until the handshake. valid stays high
  // into the next word unless a gap is drawn.
  task automatic send_word(input logic cmd, input logic [PW-1:0] pos,
                           input logic [PW-1:0] last, input logic [VB-1:0] val);
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.position  <= pos;
    in_ch.range_end <= last;
    in_ch.new_value <= val;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    if (cmd == rsmc_pkg::CMD_SET) sets_sent++;
    else queries_sent++;
    if (!steady && $urandom_range(0, 2) == 0) pause(gap_len());
  endtask

  task automatic set_at(input int pos, input logic [VB-1:0] val);
    send_word(rsmc_pkg::CMD_SET, PW'(pos), PW'($urandom), val);
  endtask

  task automatic query_span(input int first, input int last);
    send_word(rsmc_pkg::CMD_QUERY, PW'(first), PW'(last), VB'($urandom));
  endtask

  task automatic wait_results();
    while (results_due != 0) @(posedge clk);
  endtask

  // Block idle: nothing owed, and any set has finished its walk.
  task automatic settle_idle();
    pause(1);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(input int n);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= PW'(n);
    @(negedge clk);
    cfg_we   <= 1'b0;
    sizes_used++;
  endtask

  // Mostly inside the current window, sometimes 0, past the top, or all ones.
  function automatic int pick_pos(input int n);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1 && n < POS_TOP) return $urandom_range(n + 1, POS_TOP);
    if (r == 2) return POS_TOP;
    if (r == 3) return $urandom_range(1, n);
    return win_lo + $urandom_range(0, win_len - 1);
  endfunction

  // A small pool gives repeated values, so counts above one show up.
  function automatic logic [VB-1:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return VALUE_TOP;
    if (r == 2) return VB'($urandom);
    return value_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  // Tree sizes per phase: clamp cases at both ends, odd and power-of-two spans.
  int phase_sizes [0:NUM_PHASES-1] = '{POS_TOP, 3, 1, 17, 1024, 2, 64, 0, 1000, 5, 513, 256};

  initial begin
    int n, first, last, words, r, p;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    run_done        = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = rsmc_pkg::CMD_SET;
    in_ch.position  = '0;
    in_ch.range_end = '0;
    in_ch.new_value = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset size of 1024. The block clears its node
    // RAM first with ready low, so the first word just waits.
    win_lo = 1; win_len = 1;
    set_at(1, VALUE_TOP);
    set_at(1024, '0);
    set_at(2, VALUE_TOP);
    set_at(0, VB'(5));         // position 0: dropped
    set_at(POS_TOP, VB'(7));   // beyond the tree: dropped
    set_at(3, '0);
    query_span(1, 1024);       // top value twice, zero twice
    query_span(1, 1);          // single value, no second
    query_span(5, 3);          // reversed bounds
    query_span(0, POS_TOP);    // bounds past both ends
    query_span(1, 3);
    query_span(1024, 1024);
    query_span(1500, POS_TOP); // entirely outside
    query_span(4, 1023);       // only never-written leaves
    set_at(4, VALUE_TOP);
    query_span(1, 4);

    // Shrink to a single position (0 clamps up), nodes kept from before.
    settle_idle();
    write_active(0);
    set_at(1, VB'(9));
    set_at(2, VB'(3));         // above the new top: dropped
    query_span(1, 1);
    query_span(0, POS_TOP);
    settle_idle();
    write_active(2);
    set_at(2, VB'(9));
    query_span(1, 2);

    // Random phases, each under its own tree size.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_idle();
      write_active(phase_sizes[ph]);
      n = (phase_sizes[ph] < 1) ? 1 :
          (phase_sizes[ph] > rsmc_pkg::MAX_POSITIONS_DEF) ? rsmc_pkg::MAX_POSITIONS_DEF :
          phase_sizes[ph];
      steady  = ($urandom_range(0, 3) == 0);
      win_len = (n < 48) ? n : 48;
      win_lo  = $urandom_range(1, n - win_len + 1);
      pool_n  = $urandom_range(2, 6);
      for (int k = 0; k < 8; k++) value_pool[k] = VB'($urandom);
      words = 0;

      // Small trees get a full build first, so queries see a filled array.
      if (n <= 64) begin
        for (p = 1; p <= n; p++) begin
          set_at(p, pick_value());
          words++;
        end
      end

      while (words < PHASE_WORDS) begin
        // Hold off until every owed result is back, on a few phases.
        if (words == PHASE_WORDS / 2 && ph % 3 == 1) begin
          pause(1);
          wait_results();
        end
        if ($urandom_range(0, 99) < 45) begin
          p = pick_pos(n);
          set_at(p, pick_value());
          if (p >= 1 && p <= n) words++;
        end else begin
          r = $urandom_range(0, 9);
          if (r == 0) begin
            first = 1; last = n;
          end else if (r == 1) begin
            first = 0; last = POS_TOP;
          end else if (r == 2) begin
            first = pick_pos(n); last = pick_pos(n);
          end else begin
            first = pick_pos(n);
            last  = first + $urandom_range(0, win_len);
            if (last > POS_TOP) last = POS_TOP;
          end
          query_span(first, last);
          words++;
        end
      end
    end

    // Wind down: let owed results drain, then tell the checker to look for
    // leftovers before the verdict.
    settle_idle();
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("tb: %0d set words and %0d query words across %0d tree sizes",
             sets_sent, queries_sent, sizes_used);
    $display("tb: %0d results compared, %0d with a nonzero count", results_seen, nonzero_seen);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
